### rtl/dkc_pkg.sv
`default_nettype none
package dkc_pkg;

  localparam int MaxEntriesDef = 64;
  localparam int KeyBitsDef    = 32;

  // square root unit: radicand and root widths
  localparam int SqInW  = 48;
  localparam int SqOutW = 24;

  localparam logic [23:0] Q24Max = 24'hFFFFFF;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_EVAL  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_NEW     = 3'd0,
    STAT_DUP     = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_STATS   = 3'd3,
    STAT_ENTRY   = 3'd4,
    STAT_CLEARED = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RDA,
    S_RDW,
    S_WALK,
    S_MUL1,
    S_MUL2,
    S_MDIV,
    S_VDIV,
    S_SQRT,
    S_NEXT,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

### rtl/dkc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module dkc_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 21
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quo_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W:0]   rem_t;
  logic             take;

  assign rem_t = {rem_q, quo_q[NUM_W-1]};
  assign take  = rem_t >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], take};
      rem_q <= take ? DEN_W'(rem_t - {1'b0, den_q}) : rem_t[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

### rtl/dkc_sqrt.sv
`default_nettype none
// Digit-by-digit integer square root, one root bit per cycle.
module dkc_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [dkc_pkg::SqInW-1:0]   rad_i,
  output logic                             done_o,
  output logic [dkc_pkg::SqOutW-1:0]       root_o
);

  localparam int OW   = dkc_pkg::SqOutW;
  localparam int IW   = dkc_pkg::SqInW;
  localparam int RW   = OW + 2;
  localparam int CntW = $clog2(OW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [IW-1:0]   rad_q;
  logic [RW-1:0]   rem_q;
  logic [OW-1:0]   root_q;
  logic [RW+1:0]   rem_t;
  logic [RW+1:0]   trial;
  logic            take;

  assign rem_t = {rem_q, rad_q[IW-1:IW-2]};
  assign trial = (RW+2)'({root_q, 2'b01});
  assign take  = rem_t >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(OW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[IW-3:0], 2'b00};
      rem_q  <= take ? RW'(rem_t - trial) : RW'(rem_t);
      root_q <= {root_q[OW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

### rtl/distinct_key_counter_with_stats.sv
`default_nettype none
// channel | handshake             | payload
// in      | in_valid_i/in_stall_o | op, key, period, fix_count, entry_index
// out     | out_valid_o/out_stall_i | status, slot, hit_count, entry_*, entries, stats
//
// One transaction at a time; the table is one memory with a registered read port.
// Add: scans the stored keys, one stored key compared per cycle.
// Evaluate: walks the table, then per column a bit-serial division for the mean and,
// with two or more entries, one for the variance and a root unless that quotient overflows.
// Reset empties the table at once (fill count). A new transaction is taken while
// a finished result still waits on a stalled output.
module distinct_key_counter_with_stats #(
  parameter int MAX_ENTRIES = dkc_pkg::MaxEntriesDef,
  parameter int KEY_BITS    = dkc_pkg::KeyBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] key_i,
  input  wire logic [15:0] period_i,
  input  wire logic [15:0] fix_count_i,
  input  wire logic [5:0]  entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [5:0]       slot_o,
  output logic [15:0]      hit_count_o,
  output logic [15:0]      entry_period_o,
  output logic [15:0]      entry_fix_count_o,
  output logic [6:0]       entries_o,
  output logic [23:0]      mean_period_o,
  output logic [23:0]      sd_period_o,
  output logic [23:0]      mean_fixed_o,
  output logic [23:0]      sd_fixed_o,
  output logic [23:0]      mean_hits_o,
  output logic [23:0]      sd_hits_o
);

  localparam int KW  = KEY_BITS;
  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int NW  = $clog2(MAX_ENTRIES + 1);
  localparam int MW  = KW + 48;
  localparam int S1W = 16 + NW;
  localparam int S2W = 32 + NW;
  localparam int HW  = (S2W + 1) / 2;
  localparam int VW  = NW + S2W;
  localparam int DDW = 3 * NW;
  localparam int QW  = VW + 16;
  localparam int CW  = (NW > 6) ? NW : 6;

  dkc_pkg::state_e state_q, state_d;

  // table memory: key | count | period | fixed
  logic [MW-1:0] mem [MAX_ENTRIES];
  logic [MW-1:0] mem_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [MW-1:0] mem_wd;

  logic [NW-1:0] fill_q;
  logic [NW-1:0] ptr_q;
  logic          rv_q;
  logic [AW-1:0] rptr_q;
  logic          v1_q;
  logic [1:0]    col_q;

  logic [KW-1:0] key_q;
  logic [15:0]   per_q, fix_q;
  logic [5:0]    idx_q;

  logic [KW-1:0] rd_key;
  logic [15:0]   rd_cnt, rd_per, rd_fix, cnt_inc;

  logic [15:0]  x1_q  [3];
  logic [31:0]  sq1_q [3];
  logic [S1W-1:0] s1_q [3];
  logic [S2W-1:0] s2_q [3];
  logic [S1W-1:0] s1_sel;
  logic [S2W-1:0] s2_sel;

  logic [NW+HW-1:0]       pa_q;
  logic [NW+S2W-HW-1:0]   pb_q;
  logic [2*S1W-1:0]       s1sq_q;
  logic [2*NW-1:0]        nn_q;
  logic [VW-1:0]          v_q;
  logic [DDW-1:0]         d_q;

  logic [2:0]  res_status_q;
  logic [5:0]  res_slot_q;
  logic [15:0] res_hit_q, res_per_q, res_fix_q;
  logic [23:0] res_mean_q [3];
  logic [23:0] res_sd_q   [3];

  logic          in_acc, out_free;
  logic          hit, issued_all, scan_end, full, walk_done, multi, q_big, rd_ok;
  logic          div_start, div_done, sqrt_start, sqrt_done;
  logic [QW-1:0] div_a, div_q;
  logic [DDW-1:0] div_b;
  logic [23:0]   sqrt_root;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != dkc_pkg::S_IDLE);

  assign rd_key  = mem_rdata_q[MW-1:48];
  assign rd_cnt  = mem_rdata_q[47:32];
  assign rd_per  = mem_rdata_q[31:16];
  assign rd_fix  = mem_rdata_q[15:0];
  assign cnt_inc = (rd_cnt == 16'hFFFF) ? rd_cnt : rd_cnt + 16'd1;

  assign hit        = (state_q == dkc_pkg::S_SCAN) && rv_q && (rd_key == key_q);
  assign issued_all = (ptr_q == fill_q);
  assign scan_end   = issued_all && !rv_q;
  assign walk_done  = scan_end && !v1_q;
  assign full       = (fill_q == NW'(MAX_ENTRIES));
  assign multi      = (fill_q >= NW'(2));
  assign q_big      = |div_q[QW-1:dkc_pkg::SqInW];
  assign rd_ok      = CW'(idx_q) < CW'(fill_q);
  assign s1_sel     = s1_q[col_q];
  assign s2_sel     = s2_q[col_q];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rdata_q <= mem[mem_ra];
  end

  dkc_div #(.NUM_W(QW), .DEN_W(DDW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_a),
    .den_i   (div_b),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  dkc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (div_q[dkc_pkg::SqInW-1:0]),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      dkc_pkg::S_IDLE: begin
        if (in_acc) begin
          case (dkc_pkg::op_e'(op_i))
            dkc_pkg::OP_ADD:  state_d = dkc_pkg::S_SCAN;
            dkc_pkg::OP_EVAL: state_d = (fill_q == '0) ? dkc_pkg::S_DONE : dkc_pkg::S_WALK;
            dkc_pkg::OP_READ: state_d = dkc_pkg::S_RDA;
            default:          state_d = dkc_pkg::S_DONE;
          endcase
        end
      end
      dkc_pkg::S_SCAN: if (hit || scan_end) state_d = dkc_pkg::S_DONE;
      dkc_pkg::S_RDA:  state_d = dkc_pkg::S_RDW;
      dkc_pkg::S_RDW:  state_d = dkc_pkg::S_DONE;
      dkc_pkg::S_WALK: if (walk_done) state_d = dkc_pkg::S_MUL1;
      dkc_pkg::S_MUL1: state_d = dkc_pkg::S_MUL2;
      dkc_pkg::S_MUL2: state_d = dkc_pkg::S_MDIV;
      dkc_pkg::S_MDIV: begin
        if (div_done) state_d = multi ? dkc_pkg::S_VDIV : dkc_pkg::S_NEXT;
      end
      dkc_pkg::S_VDIV: begin
        if (div_done) state_d = q_big ? dkc_pkg::S_NEXT : dkc_pkg::S_SQRT;
      end
      dkc_pkg::S_SQRT: if (sqrt_done) state_d = dkc_pkg::S_NEXT;
      dkc_pkg::S_NEXT: state_d = (col_q == 2'd2) ? dkc_pkg::S_DONE : dkc_pkg::S_MUL1;
      dkc_pkg::S_DONE: if (out_free) state_d = dkc_pkg::S_IDLE;
      default:         state_d = dkc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_wa     = rptr_q;
    mem_wd     = {key_q, cnt_inc, rd_per, rd_fix};
    mem_ra     = ptr_q[AW-1:0];
    div_start  = 1'b0;
    div_a      = QW'({s1_sel, 8'b0});
    div_b      = DDW'(fill_q);
    sqrt_start = 1'b0;
    case (state_q)
      dkc_pkg::S_SCAN: begin
        if (hit) begin
          mem_we = 1'b1;
        end else if (scan_end && !full) begin
          mem_we = 1'b1;
          mem_wa = fill_q[AW-1:0];
          mem_wd = {key_q, 16'd1, per_q, fix_q};
        end
      end
      dkc_pkg::S_RDA:  mem_ra = AW'(idx_q);
      dkc_pkg::S_MUL2: div_start = 1'b1;
      dkc_pkg::S_MDIV: begin
        if (div_done && multi) begin
          div_start = 1'b1;
          div_a     = QW'({v_q, 16'b0});
          div_b     = d_q;
        end
      end
      dkc_pkg::S_VDIV: sqrt_start = div_done && !q_big;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dkc_pkg::S_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      rv_q        <= 1'b0;
      v1_q        <= 1'b0;
      col_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && dkc_pkg::op_e'(op_i) == dkc_pkg::OP_CLEAR) begin
        fill_q <= '0;
      end else if (state_q == dkc_pkg::S_SCAN && !hit && scan_end && !full) begin
        fill_q <= fill_q + NW'(1);
      end
      if (state_q == dkc_pkg::S_SCAN || state_q == dkc_pkg::S_WALK) begin
        if (!issued_all && !hit) ptr_q <= ptr_q + NW'(1);
        rv_q <= !issued_all && !hit;
      end else begin
        ptr_q <= '0;
        rv_q  <= 1'b0;
      end
      v1_q <= rv_q && (state_q == dkc_pkg::S_WALK);
      if (state_q == dkc_pkg::S_WALK) begin
        col_q <= '0;
      end else if (state_q == dkc_pkg::S_NEXT) begin
        col_q <= col_q + 2'd1;
      end
      if (state_q == dkc_pkg::S_DONE && out_free) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rptr_q <= ptr_q[AW-1:0];
    x1_q[0]  <= rd_per;
    x1_q[1]  <= rd_fix;
    x1_q[2]  <= rd_cnt;
    sq1_q[0] <= 32'(rd_per) * 32'(rd_per);
    sq1_q[1] <= 32'(rd_fix) * 32'(rd_fix);
    sq1_q[2] <= 32'(rd_cnt) * 32'(rd_cnt);

    if (in_acc) begin
      key_q        <= KW'(key_i);
      per_q        <= period_i;
      fix_q        <= fix_count_i;
      idx_q        <= entry_index_i;
      res_slot_q   <= (dkc_pkg::op_e'(op_i) == dkc_pkg::OP_READ) ? entry_index_i : '0;
      res_hit_q    <= '0;
      res_per_q    <= '0;
      res_fix_q    <= '0;
      for (int c = 0; c < 3; c++) begin
        res_mean_q[c] <= '0;
        res_sd_q[c]   <= '0;
        s1_q[c]       <= '0;
        s2_q[c]       <= '0;
      end
      case (dkc_pkg::op_e'(op_i))
        dkc_pkg::OP_ADD:  res_status_q <= dkc_pkg::STAT_FULL;
        dkc_pkg::OP_EVAL: res_status_q <= dkc_pkg::STAT_STATS;
        dkc_pkg::OP_READ: res_status_q <= dkc_pkg::STAT_ENTRY;
        default:          res_status_q <= dkc_pkg::STAT_CLEARED;
      endcase
    end

    if (state_q == dkc_pkg::S_SCAN) begin
      if (hit) begin
        res_status_q <= dkc_pkg::STAT_DUP;
        res_slot_q   <= 6'(rptr_q);
        res_hit_q    <= cnt_inc;
        res_per_q    <= rd_per;
        res_fix_q    <= rd_fix;
      end else if (scan_end && !full) begin
        res_status_q <= dkc_pkg::STAT_NEW;
        res_slot_q   <= 6'(fill_q);
        res_hit_q    <= 16'd1;
        res_per_q    <= per_q;
        res_fix_q    <= fix_q;
      end
    end

    if (state_q == dkc_pkg::S_RDW && rd_ok) begin
      res_hit_q <= rd_cnt;
      res_per_q <= rd_per;
      res_fix_q <= rd_fix;
    end

    if (v1_q) begin
      for (int c = 0; c < 3; c++) begin
        s1_q[c] <= s1_q[c] + S1W'(x1_q[c]);
        s2_q[c] <= s2_q[c] + S2W'(sq1_q[c]);
      end
    end

    if (state_q == dkc_pkg::S_MUL1) begin
      pa_q   <= (NW+HW)'(fill_q) * (NW+HW)'(s2_sel[HW-1:0]);
      pb_q   <= (NW+S2W-HW)'(fill_q) * (NW+S2W-HW)'(s2_sel[S2W-1:HW]);
      s1sq_q <= (2*S1W)'(s1_sel) * (2*S1W)'(s1_sel);
      nn_q   <= (2*NW)'(fill_q) * (2*NW)'(fill_q);
    end
    if (state_q == dkc_pkg::S_MUL2) begin
      v_q <= VW'(pa_q) + (VW'(pb_q) << HW) - VW'(s1sq_q);
      d_q <= DDW'(nn_q) * DDW'(fill_q - NW'(1));
    end
    if (state_q == dkc_pkg::S_MDIV && div_done) begin
      res_mean_q[col_q] <= (|div_q[QW-1:24]) ? dkc_pkg::Q24Max : div_q[23:0];
    end
    if (state_q == dkc_pkg::S_VDIV && div_done && q_big) begin
      res_sd_q[col_q] <= dkc_pkg::Q24Max;
    end
    if (state_q == dkc_pkg::S_SQRT && sqrt_done) begin
      res_sd_q[col_q] <= sqrt_root;
    end

    if (state_q == dkc_pkg::S_DONE && out_free) begin
      status_o            <= res_status_q;
      slot_o              <= res_slot_q;
      hit_count_o         <= res_hit_q;
      entry_period_o      <= res_per_q;
      entry_fix_count_o   <= res_fix_q;
      entries_o           <= 7'(fill_q);
      mean_period_o       <= res_mean_q[0];
      sd_period_o         <= res_sd_q[0];
      mean_fixed_o        <= res_mean_q[1];
      sd_fixed_o          <= res_sd_q[1];
      mean_hits_o         <= res_mean_q[2];
      sd_hits_o           <= res_sd_q[2];
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NW'(MAX_ENTRIES))
    else $error("fill level beyond table depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (NW'(rptr_q) < fill_q))
    else $error("scan read of an entry beyond fill level");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == dkc_pkg::STAT_CLEARED) |-> (entries_o == 7'd0))
    else $error("cleared result reports entries");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_start && sqrt_start))
    else $error("divider and root started together");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 64;
  localparam int WatchdogLimit = 20000;
  localparam int LongHoldCycles = 300;
  localparam int ColPeriod = 0;
  localparam int ColFixed = 1;
  localparam int ColHits = 2;

  typedef struct packed {
    dkc_pkg::status_e status;
    logic [5:0]  slot;
    logic [15:0] hit_count;
    logic [15:0] entry_period;
    logic [15:0] entry_fixed;
    logic [6:0]  entries;
    logic [23:0] mean_period;
    logic [23:0] sd_period;
    logic [23:0] mean_fixed;
    logic [23:0] sd_fixed;
    logic [23:0] mean_hits;
    logic [23:0] sd_hits;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = dkc_pkg::OP_ADD;
  logic [31:0] key = '0;
  logic [15:0] period = '0;
  logic [15:0] fix_count = '0;
  logic [5:0]  entry_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [15:0] hit_count, entry_period, entry_fix_count;
  logic [6:0]  entries;
  logic [23:0] mean_period, sd_period, mean_fixed, sd_fixed, mean_hits, sd_hits;

  // shadow copy of the table
  logic [31:0] shadow_keys [TableDepth];
  logic [15:0] shadow_hits [TableDepth];
  logic [15:0] shadow_period [TableDepth];
  logic [15:0] shadow_fixed [TableDepth];
  int          shadow_fill = 0;

  table_result_t expected_results[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          long_hold = 1'b0;
  int          quiet_cycles = 0;
  logic [31:0] key_pool [16];

  always #6 clk = ~clk;

  distinct_key_counter_with_stats DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .key_i(key), .period_i(period), .fix_count_i(fix_count),
    .entry_index_i(entry_index),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .slot_o(slot), .hit_count_o(hit_count),
    .entry_period_o(entry_period), .entry_fix_count_o(entry_fix_count),
    .entries_o(entries),
    .mean_period_o(mean_period), .sd_period_o(sd_period),
    .mean_fixed_o(mean_fixed), .sd_fixed_o(sd_fixed),
    .mean_hits_o(mean_hits), .sd_hits_o(sd_hits)
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [23:0] clip24(longint unsigned v);
    return (v > dkc_pkg::Q24Max) ? dkc_pkg::Q24Max : v[23:0];
  endfunction

  function automatic void column_stats(int col, int n, output logic [23:0] mean,
                                       output logic [23:0] spread);
    longint unsigned s1 = 0, s2 = 0, x, v, d, q, nn;
    for (int i = 0; i < n; i++) begin
      case (col)
        ColPeriod: x = shadow_period[i];
        ColFixed:  x = shadow_fixed[i];
        default:   x = shadow_hits[i];
      endcase
      s1 += x;
      s2 += x * x;
    end
    nn = n;
    mean = clip24((s1 * 256) / nn);
    if (n < 2) begin
      spread = '0;
    end else begin
      v = nn * s2 - s1 * s1;
      d = nn * nn * (nn - 1);
      q = (v / d) * 65536 + ((v % d) * 65536) / d;
      spread = clip24(int_sqrt(q));
    end
  endfunction

  function automatic table_result_t table_update(logic [1:0] o, logic [31:0] k,
      logic [15:0] p, logic [15:0] f, logic [5:0] idx);
    table_result_t r = '0;
    int hit = -1;
    case (dkc_pkg::op_e'(o))
      dkc_pkg::OP_ADD: begin
        for (int i = 0; i < shadow_fill; i++)
          if (hit < 0 && shadow_keys[i] == k) hit = i;
        if (hit >= 0) begin
          if (shadow_hits[hit] != 16'hFFFF) shadow_hits[hit]++;
          r.status = dkc_pkg::STAT_DUP;
        end else if (shadow_fill < TableDepth) begin
          hit = shadow_fill;
          shadow_keys[hit] = k;
          shadow_hits[hit] = 16'd1;
          shadow_period[hit] = p;
          shadow_fixed[hit] = f;
          shadow_fill++;
          r.status = dkc_pkg::STAT_NEW;
        end else begin
          r.status = dkc_pkg::STAT_FULL;
        end
        if (hit >= 0) begin
          r.slot = hit[5:0];
          r.hit_count = shadow_hits[hit];
          r.entry_period = shadow_period[hit];
          r.entry_fixed = shadow_fixed[hit];
        end
      end
      dkc_pkg::OP_EVAL: begin
        r.status = dkc_pkg::STAT_STATS;
        if (shadow_fill > 0) begin
          column_stats(ColPeriod, shadow_fill, r.mean_period, r.sd_period);
          column_stats(ColFixed, shadow_fill, r.mean_fixed, r.sd_fixed);
          column_stats(ColHits, shadow_fill, r.mean_hits, r.sd_hits);
        end
      end
      dkc_pkg::OP_READ: begin
        r.status = dkc_pkg::STAT_ENTRY;
        r.slot = idx;
        if (idx < shadow_fill) begin
          r.hit_count = shadow_hits[idx];
          r.entry_period = shadow_period[idx];
          r.entry_fixed = shadow_fixed[idx];
        end
      end
      default: begin
        shadow_fill = 0;
        r.status = dkc_pkg::STAT_CLEARED;
      end
    endcase
    r.entries = shadow_fill[6:0];
    return r;
  endfunction

  task automatic send_item(logic [1:0] o, logic [31:0] k, logic [15:0] p,
                           logic [15:0] f, logic [5:0] idx);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      op <= dkc_pkg::OP_ADD;
      key <= $urandom;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    op <= o;
    key <= k;
    period <= p;
    fix_count <= f;
    entry_index <= idx;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(table_update(o, k, p, f, idx));
  endtask

  // stop offering and wait for every outstanding transaction to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic compare_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t exp;
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual status %0d", $realtime,
                 status);
        error_count++;
      end else begin
        exp = expected_results.pop_front();
        compare_field("status", exp.status, status);
        compare_field("slot", exp.slot, slot);
        compare_field("hit_count", exp.hit_count, hit_count);
        compare_field("entry_period", exp.entry_period, entry_period);
        compare_field("entry_fix_count", exp.entry_fixed, entry_fix_count);
        compare_field("entries", exp.entries, entries);
        compare_field("mean_period", exp.mean_period, mean_period);
        compare_field("sd_period", exp.sd_period, sd_period);
        compare_field("mean_fixed", exp.mean_fixed, mean_fixed);
        compare_field("sd_fixed", exp.sd_fixed, sd_fixed);
        compare_field("mean_hits", exp.mean_hits, mean_hits);
        compare_field("sd_hits", exp.sd_hits, sd_hits);
      end
    end
  end

  // receiver stall; a long hold is counted here
  always @(posedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
      repeat (LongHoldCycles) @(posedge clk);
      long_hold = 1'b0;
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(dkc_pkg::OP_EVAL, '0, '0, '0, '0);
    send_item(dkc_pkg::OP_READ, '0, '0, '0, '0);
    send_item(dkc_pkg::OP_ADD, 32'h0, 16'h0, 16'h0, '0);
    send_item(dkc_pkg::OP_EVAL, '0, '0, '0, '0);
    send_item(dkc_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 6'h3F);
    send_item(dkc_pkg::OP_ADD, 32'h0, 16'h1234, 16'h4321, '0);
    send_item(dkc_pkg::OP_ADD, 32'hFFFF_FFFE, 16'h8000, 16'h0001, '0);
    send_item(dkc_pkg::OP_EVAL, '0, '0, '0, '0);
    send_item(dkc_pkg::OP_READ, '0, '0, '0, 6'd0);
    send_item(dkc_pkg::OP_READ, '0, '0, '0, 6'd1);
    send_item(dkc_pkg::OP_READ, '0, '0, '0, 6'd3);
    send_item(dkc_pkg::OP_READ, '0, '0, '0, 6'h3F);
    send_item(dkc_pkg::OP_CLEAR, '0, '0, '0, '0);
    send_item(dkc_pkg::OP_EVAL, '0, '0, '0, '0);
    send_item(dkc_pkg::OP_READ, '0, '0, '0, 6'd0);
    drain_results();
  endtask

  task automatic test_full_table();
    logic [31:0] k;
    for (int i = 0; i < TableDepth; i++) begin
      k = {26'($urandom_range(32'h03FF_FFFF)), i[5:0]};
      send_item(dkc_pkg::OP_ADD, k, (i == 0) ? 16'hFFFF : 16'($urandom),
                (i == 1) ? 16'hFFFF : 16'($urandom), '0);
    end
    send_item(dkc_pkg::OP_ADD, 32'hA5A5_A5C0, 16'h1, 16'h1, '0);   // low bits collide, key differs
    send_item(dkc_pkg::OP_ADD, shadow_keys[TableDepth - 1], '0, '0, '0);
    send_item(dkc_pkg::OP_EVAL, '0, '0, '0, '0);
    send_item(dkc_pkg::OP_READ, '0, '0, '0, 6'h3F);
    send_item(dkc_pkg::OP_CLEAR, '0, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    int pick;
    logic [31:0] k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      k = ($urandom_range(3) == 0) ? $urandom : key_pool[$urandom_range(15)];
      if (pick < 65)
        send_item(dkc_pkg::OP_ADD, k, 16'($urandom), 16'($urandom), 6'($urandom));
      else if (pick < 77)
        send_item(dkc_pkg::OP_EVAL, $urandom, 16'($urandom), 16'($urandom),
                  6'($urandom));
      else if (pick < 97)
        send_item(dkc_pkg::OP_READ, $urandom, 16'($urandom), 16'($urandom),
                  ($urandom_range(1) && shadow_fill > 0) ?
                  6'($urandom_range(shadow_fill - 1)) : 6'($urandom));
      else
        send_item(dkc_pkg::OP_CLEAR, $urandom, 16'($urandom), 16'($urandom),
                  6'($urandom));
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold = 1'b1;
    for (int n = 0; n < 8; n++)
      send_item(dkc_pkg::OP_ADD, key_pool[$urandom_range(3)], 16'($urandom),
                16'($urandom), '0);
    send_item(dkc_pkg::OP_EVAL, '0, '0, '0, '0);
    drain_results();
  endtask

  task automatic test_repeat_hits();
    logic [31:0] k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    k = $urandom;
    send_item(dkc_pkg::OP_CLEAR, '0, '0, '0, '0);
    for (int n = 0; n < 10; n++)
      send_item(dkc_pkg::OP_ADD, k, 16'($urandom), 16'($urandom), '0);
    send_item(dkc_pkg::OP_ADD, ~k, 16'h0, 16'h0, '0);
    send_item(dkc_pkg::OP_EVAL, '0, '0, '0, '0);
    send_item(dkc_pkg::OP_READ, '0, '0, '0, 6'd0);
    send_item(dkc_pkg::OP_CLEAR, '0, '0, '0, '0);
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(100, 12, 48);
    test_backpressure();
    test_random(100, 48, 12);
    test_random(100, 0, 0);
    test_repeat_hits();
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

### distinct_key_counter_with_stats.f
rtl/dkc_pkg.sv
rtl/dkc_div.sv
rtl/dkc_sqrt.sv
rtl/distinct_key_counter_with_stats.sv
tb/testbench.sv
